### rtl/tkd_pkg.sv
// Shared types and constants for the two-key debounce and long-press unit.
`default_nettype none

package tkd_pkg;

    localparam int CountWidth = 8;
    localparam int CodeWidth  = 4;
    localparam int CfgIdxWidth = 4;

    localparam logic [CodeWidth-1:0] KEY_NONE    = 4'd0;
    localparam logic [CodeWidth-1:0] KEY_OK_DN   = 4'd1;
    localparam logic [CodeWidth-1:0] KEY_OK_UP   = 4'd2;
    localparam logic [CodeWidth-1:0] KEY_MENU_DN = 4'd3;
    localparam logic [CodeWidth-1:0] KEY_MENU_UP = 4'd4;
    localparam logic [CodeWidth-1:0] KEY_PWR_DN  = 4'd5;
    localparam logic [CodeWidth-1:0] KEY_PWR_UP  = 4'd6;
    localparam logic [CodeWidth-1:0] KEY_PLUS_DN = 4'd7;
    localparam logic [CodeWidth-1:0] KEY_PLUS_UP = 4'd8;

    localparam logic [CfgIdxWidth-1:0] CFG_PRESS_DEBOUNCE   = 4'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_RELEASE_DEBOUNCE = 4'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_MENU_HOLD        = 4'd2;
    localparam logic [CfgIdxWidth-1:0] CFG_POWER_HOLD       = 4'd3;

    localparam logic [CountWidth-1:0] PRESS_DEBOUNCE_RESET   = 8'd8;
    localparam logic [CountWidth-1:0] RELEASE_DEBOUNCE_RESET = 8'd16;
    localparam logic [CountWidth-1:0] MENU_HOLD_RESET        = 8'd32;
    localparam logic [CountWidth-1:0] POWER_HOLD_RESET       = 8'd160;

    typedef struct packed {
        logic [CountWidth-1:0] press_debounce_ticks;
        logic [CountWidth-1:0] release_debounce_ticks;
        logic [CountWidth-1:0] menu_hold_ticks;
        logic [CountWidth-1:0] power_hold_ticks;
    } cfg_t;

    typedef struct packed {
        logic tick_valid;
        logic main_released;
        logic plus_released;
    } key_req_t;

endpackage

`default_nettype wire

### rtl/two_key_debounce_long_press_unit.sv
// Top level of the two-key debounce and long-press unit.
//
// Each request carries one tick with the levels of the active-low main and
// plus key pins, and each request yields exactly one result: the last key
// event code and a flag that is set when that tick produced an event. The
// unit takes one request per clock cycle while it is not stalled; a request
// passes through an input register and the key state machine into the result
// register. The result register doubles as the key state, so the unit keeps
// accepting while a result waits to be taken and stalls only when both the
// input and the result register are full and the result is not taken.
// Configuration writes take effect at the next counter load.
`default_nettype none

module two_key_debounce_long_press_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            tick_valid,
    input  wire logic                            main_released,
    input  wire logic                            plus_released,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [tkd_pkg::CodeWidth-1:0]        key_code,
    output logic                                 key_new,
    input  wire logic                            cfg_write_en,
    input  wire logic [tkd_pkg::CfgIdxWidth-1:0] cfg_index,
    input  wire logic [tkd_pkg::CountWidth-1:0]  cfg_data
);

    import tkd_pkg::*;

    cfg_t     cfg;
    key_req_t req_reg;
    logic     req_valid_reg, req_valid_next;
    logic     out_valid_reg, out_valid_next;
    logic     advance;

    assign advance  = req_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !req_valid_reg || advance;

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (in_valid && in_ready)
        begin
            req_valid_next = 1'b1;
        end
        else if (advance)
        begin
            req_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg.tick_valid    <= tick_valid;
            req_reg.main_released <= main_released;
            req_reg.plus_released <= plus_released;
        end
    end

    tkd_cfg_regs u_cfg_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    tkd_key_fsm u_key_fsm (
        .clk      (clk),
        .rst_n    (rst_n),
        .step_en  (advance),
        .req      (req_reg),
        .cfg      (cfg),
        .key_code (key_code),
        .key_new  (key_new)
    );

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

### rtl/tkd_cfg_regs.sv
// Configuration register file for the debounce and hold timings.
`default_nettype none

module tkd_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write_en,
    input  wire logic [tkd_pkg::CfgIdxWidth-1:0] cfg_index,
    input  wire logic [tkd_pkg::CountWidth-1:0]  cfg_data,
    output tkd_pkg::cfg_t                       cfg
);

    import tkd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_PRESS_DEBOUNCE:   cfg_next.press_debounce_ticks   = cfg_data;
                CFG_RELEASE_DEBOUNCE: cfg_next.release_debounce_ticks = cfg_data;
                CFG_MENU_HOLD:        cfg_next.menu_hold_ticks        = cfg_data;
                CFG_POWER_HOLD:       cfg_next.power_hold_ticks       = cfg_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.press_debounce_ticks   <= PRESS_DEBOUNCE_RESET;
            cfg_reg.release_debounce_ticks <= RELEASE_DEBOUNCE_RESET;
            cfg_reg.menu_hold_ticks        <= MENU_HOLD_RESET;
            cfg_reg.power_hold_ticks       <= POWER_HOLD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### rtl/tkd_key_fsm.sv
// Key mode state machine with debounce and hold counters and the result register.
`default_nettype none

module tkd_key_fsm (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          step_en,
    input  wire tkd_pkg::key_req_t             req,
    input  wire tkd_pkg::cfg_t                 cfg,
    output logic [tkd_pkg::CodeWidth-1:0]      key_code,
    output logic                               key_new
);

    import tkd_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_OK    = 3'd1,
        MODE_MENU  = 3'd2,
        MODE_POWER = 3'd3,
        MODE_PLUS  = 3'd4
    } mode_t;

    mode_t                 mode_reg, mode_next;
    logic [CountWidth-1:0] debounce_reg, debounce_next;
    logic [CountWidth-1:0] hold_reg, hold_next;
    logic [CountWidth-1:0] hold_dec;
    logic [CodeWidth-1:0]  last_key_reg, last_key_next;
    logic                  key_new_reg, key_new_next;
    logic                  fresh;

    assign hold_dec = (hold_reg != '0) ? hold_reg - 1'b1 : hold_reg;

    always_comb
    begin
        mode_next     = mode_reg;
        debounce_next = debounce_reg;
        hold_next     = hold_reg;
        last_key_next = last_key_reg;
        fresh         = 1'b0;

        if (req.tick_valid)
        begin
            hold_next = hold_dec;
            if (debounce_reg != '0)
            begin
                debounce_next = debounce_reg - 1'b1;
            end
            else
            begin
                unique case (mode_reg)
                    MODE_OK:
                    begin
                        if (req.main_released)
                        begin
                            last_key_next = KEY_OK_UP;
                            mode_next     = MODE_IDLE;
                            debounce_next = cfg.release_debounce_ticks;
                            fresh         = 1'b1;
                        end
                        else if (hold_dec == '0)
                        begin
                            last_key_next = KEY_MENU_DN;
                            mode_next     = MODE_MENU;
                            hold_next     = cfg.power_hold_ticks;
                            fresh         = 1'b1;
                        end
                    end
                    MODE_MENU:
                    begin
                        if (req.main_released)
                        begin
                            last_key_next = KEY_MENU_UP;
                            mode_next     = MODE_IDLE;
                            debounce_next = cfg.release_debounce_ticks;
                            fresh         = 1'b1;
                        end
                        else if (hold_dec == '0)
                        begin
                            last_key_next = KEY_PWR_DN;
                            mode_next     = MODE_POWER;
                            fresh         = 1'b1;
                        end
                    end
                    MODE_POWER:
                    begin
                        if (req.main_released)
                        begin
                            last_key_next = KEY_PWR_UP;
                            mode_next     = MODE_IDLE;
                            debounce_next = cfg.release_debounce_ticks;
                            fresh         = 1'b1;
                        end
                    end
                    MODE_PLUS:
                    begin
                        if (req.plus_released)
                        begin
                            last_key_next = KEY_PLUS_UP;
                            mode_next     = MODE_IDLE;
                            debounce_next = cfg.release_debounce_ticks;
                            fresh         = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (!req.main_released)
                        begin
                            last_key_next = KEY_OK_DN;
                            mode_next     = MODE_OK;
                            debounce_next = cfg.press_debounce_ticks;
                            hold_next     = cfg.menu_hold_ticks;
                            fresh         = 1'b1;
                        end
                        else if (!req.plus_released)
                        begin
                            last_key_next = KEY_PLUS_DN;
                            mode_next     = MODE_PLUS;
                            debounce_next = cfg.press_debounce_ticks;
                            fresh         = 1'b1;
                        end
                    end
                endcase
            end
        end

        key_new_next = fresh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            debounce_reg <= '0;
            hold_reg     <= '0;
            last_key_reg <= KEY_NONE;
            key_new_reg  <= 1'b0;
        end
        else if (step_en)
        begin
            mode_reg     <= mode_next;
            debounce_reg <= debounce_next;
            hold_reg     <= hold_next;
            last_key_reg <= last_key_next;
            key_new_reg  <= key_new_next;
        end
    end

    assign key_code = last_key_reg;
    assign key_new  = key_new_reg;

endmodule

`default_nettype wire

### rtl/tkd_checker.sv
// Port-level checker for the two-key debounce and long-press unit, with its bind.
`default_nettype none

module tkd_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            in_valid,
    input wire logic                            in_ready,
    input wire logic                            out_valid,
    input wire logic                            out_ready,
    input wire logic [tkd_pkg::CodeWidth-1:0]   key_code,
    input wire logic                            key_new
);

    import tkd_pkg::*;

    // A stalled result must hold its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(key_code) && $stable(key_new))
    else $error("Stalled result changed.");

    // Only defined event codes ever appear on the result.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> key_code <= KEY_PLUS_UP)
    else $error("Key code out of range.");

    // A fresh event always carries a real key code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && key_new |-> key_code != KEY_NONE)
    else $error("Fresh event without a key code.");

    // With no result pending, the unit must be able to take a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
    else $error("Request refused while the output is empty.");

    // A request accepted into an empty unit reaches the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && in_valid && in_ready ##1 !out_valid |=> out_valid)
    else $error("Result did not appear after a request.");

endmodule

bind two_key_debounce_long_press_unit tkd_checker u_tkd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .key_code  (key_code),
    .key_new   (key_new)
);

`default_nettype wire
